/* hdl/cbsm_pkg.sv */
package cbsm_pkg;

  // Bus and window geometry
  localparam int unsigned ADDR_W       = 24;
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned ROM_W        = 25;
  localparam int unsigned WINDOW_BYTES = 4194304;
  localparam int unsigned BOOT_BYTES   = 8192;
  localparam int unsigned UNIT_SHIFT   = 17;
  localparam int unsigned UNIT_W       = 5;
  localparam int unsigned WIN_BITS     = $clog2(WINDOW_BYTES);
  localparam int unsigned BOOT_BITS    = $clog2(BOOT_BYTES);
  localparam int unsigned QUOT_W       = WIN_BITS - UNIT_SHIFT;
  localparam int unsigned CNT_W        = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;
  localparam int unsigned STATUS_W     = 3;

  // Configuration port
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam logic        REG_ROM_BYTES = 1'b0;
  localparam logic [ROM_W-1:0] ROM_BYTES_RESET = ROM_W'(524288);

  // Mapper register addresses
  localparam logic [ADDR_W-1:0] ADDR_BANK_HIGH = 24'h400000;
  localparam logic [ADDR_W-1:0] ADDR_SIZE      = 24'h402000;
  localparam logic [ADDR_W-1:0] ADDR_BANK_LOW  = 24'h404000;

  // Commands
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_READ_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_READ_OUTSIDE = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_REMAPPED     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_STORED       = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED      = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN      = 3'd5;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   rom_addr;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

/* hdl/cartridge_bank_size_mapper_core.sv */
// Channel  | handshake                   | payload
// ---------+-----------------------------+----------------------------------
// req      | req_valid / req_ready       | command, addr, data (req_t)
// rsp      | rsp_valid / rsp_ready       | rom_addr, status (rsp_t)
// apb      | psel penable pwrite pready  | paddr, pwdata, prdata (rom_bytes)
//
// A word is registered on acceptance; ST_FINISH loads its result. A read in
// the remapped window first passes ST_DIVIDE, where one shared 5-bit
// compare-subtract unit runs a restoring modulo of the 128 KB unit index;
// req_ready is low until the result is loaded. A pending result in the output
// register holds the sequencer until rsp_ready takes it.
// rst is synchronous and returns the mapper to boot mode with no pending word.
module cartridge_bank_size_mapper_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  cbsm_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output cbsm_pkg::rsp_t                  rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbsm_pkg::PADDR_W-1:0]    paddr,
  input  logic [cbsm_pkg::PDATA_W-1:0]    pwdata,
  output logic [cbsm_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t                          state;
  cbsm_pkg::req_t                  item;
  logic [cbsm_pkg::ROM_W-1:0]      rom_bytes;
  logic [1:0]                      bank_high_bits;
  logic [2:0]                      bank_low_bits;
  logic                            bank_written;
  logic [cbsm_pkg::UNIT_W-1:0]     size_units;
  logic                            size_written;
  logic                            boot_mode;
  logic [cbsm_pkg::UNIT_W-1:0]     mapped_base_units;
  logic [cbsm_pkg::UNIT_W-1:0]     mapped_size_units;
  logic [cbsm_pkg::UNIT_W-1:0]     rem;
  logic [cbsm_pkg::QUOT_W-1:0]     dvd;
  logic [cbsm_pkg::CNT_W-1:0]      cnt;

  // Shared compare-subtract unit
  logic [cbsm_pkg::UNIT_W:0]       trial;
  logic [cbsm_pkg::UNIT_W:0]       trial_diff;
  logic                            trial_ge;
  logic [cbsm_pkg::UNIT_W-1:0]     rem_next;

  // Result evaluation
  logic                            in_window;
  logic                            needs_divide;
  logic [cbsm_pkg::ROM_W-1:0]      boot_base;
  logic [cbsm_pkg::ROM_W-1:0]      boot_sum;
  logic [cbsm_pkg::WIN_BITS-1:0]   map_off;
  logic [cbsm_pkg::WIN_BITS:0]     map_sum;
  logic                            is_bh, is_sz, is_bl, known;
  logic [1:0]                      nbh;
  logic [2:0]                      nbl;
  logic [cbsm_pkg::UNIT_W-1:0]     nsz;
  logic                            nbw, nsw, changed, refuse;
  logic [cbsm_pkg::ROM_W:0]        bank_b, size_b, rom_ext;
  cbsm_pkg::rsp_t                  result;
  logic                            do_remap;
  logic                            rsp_free;

  assign req_ready = (state == ST_IDLE);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == cbsm_pkg::REG_ROM_BYTES) ?
                     cbsm_pkg::PDATA_W'(rom_bytes) : '0;
  assign rsp_free  = !rsp_valid || rsp_ready;

  // Decide on acceptance whether the read needs the modulo
  assign in_window    = (req.addr < cbsm_pkg::ADDR_W'(cbsm_pkg::WINDOW_BYTES));
  assign needs_divide = (req.command == cbsm_pkg::CMD_READ) && in_window &&
                        !boot_mode && (mapped_size_units != '0);

  // One restoring step: shift in a dividend bit, subtract where it fits
  assign trial      = {rem, dvd[cbsm_pkg::QUOT_W-1]};
  assign trial_diff = trial - {1'b0, mapped_size_units};
  assign trial_ge   = (trial >= {1'b0, mapped_size_units});
  assign rem_next   = trial_ge ? trial_diff[cbsm_pkg::UNIT_W-1:0]
                               : trial[cbsm_pkg::UNIT_W-1:0];

  // Read translation
  assign boot_base = (rom_bytes >= cbsm_pkg::ROM_W'(cbsm_pkg::BOOT_BYTES)) ?
                     rom_bytes - cbsm_pkg::ROM_W'(cbsm_pkg::BOOT_BYTES) : '0;
  assign boot_sum  = boot_base + cbsm_pkg::ROM_W'(item.addr[cbsm_pkg::BOOT_BITS-1:0]);
  assign map_off   = (mapped_size_units == '0) ? item.addr[cbsm_pkg::WIN_BITS-1:0] :
                     cbsm_pkg::WIN_BITS'({rem, item.addr[cbsm_pkg::UNIT_SHIFT-1:0]});
  assign map_sum   = {1'b0, map_off} +
                     (cbsm_pkg::WIN_BITS+1)'({mapped_base_units,
                                             {cbsm_pkg::UNIT_SHIFT{1'b0}}});

  // Write decode and remap check
  assign is_bh   = (item.addr == cbsm_pkg::ADDR_BANK_HIGH);
  assign is_sz   = (item.addr == cbsm_pkg::ADDR_SIZE);
  assign is_bl   = (item.addr == cbsm_pkg::ADDR_BANK_LOW);
  assign known   = is_bh || is_sz || is_bl;
  assign nbh     = is_bh ? item.data[2:1] : bank_high_bits;
  assign nbl     = is_bl ? item.data[2:0] : bank_low_bits;
  assign nsz     = is_sz ? item.data[cbsm_pkg::UNIT_W-1:0] : size_units;
  assign nbw     = bank_written || is_bh || is_bl;
  assign nsw     = size_written || is_sz;
  assign changed = ({nbh, nbl} != {bank_high_bits, bank_low_bits}) ||
                   (nsz != size_units) || (nbw != bank_written) ||
                   (nsw != size_written);
  assign bank_b  = (cbsm_pkg::ROM_W+1)'({nbh, nbl, {cbsm_pkg::UNIT_SHIFT{1'b0}}});
  assign size_b  = (cbsm_pkg::ROM_W+1)'({nsz, {cbsm_pkg::UNIT_SHIFT{1'b0}}});
  assign rom_ext = {1'b0, rom_bytes};
  assign refuse  = (nsz == '0) || (bank_b >= rom_ext) || ((bank_b + size_b) > rom_ext);

  // Form the result word
  always_comb begin
    result   = '0;
    do_remap = 1'b0;
    if (item.command == cbsm_pkg::CMD_READ) begin
      if (item.addr >= cbsm_pkg::ADDR_W'(cbsm_pkg::WINDOW_BYTES)) begin
        result.status = cbsm_pkg::STATUS_READ_OUTSIDE;
      end else if (boot_mode) begin
        result.rom_addr = boot_sum[cbsm_pkg::ADDR_W-1:0];
        result.status   = cbsm_pkg::STATUS_READ_OK;
      end else begin
        result.rom_addr = cbsm_pkg::ADDR_W'(map_sum);
        result.status   = cbsm_pkg::STATUS_READ_OK;
      end
    end else if (!known) begin
      result.status = cbsm_pkg::STATUS_UNKNOWN;
    end else if (nbw && nsw && changed) begin
      if (refuse) begin
        result.status = cbsm_pkg::STATUS_REFUSED;
      end else begin
        result.status = cbsm_pkg::STATUS_REMAPPED;
        do_remap      = 1'b1;
      end
    end else begin
      result.status = cbsm_pkg::STATUS_STORED;
    end
  end

  // Sequencer, mapper state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      rsp_valid         <= 1'b0;
      rom_bytes         <= cbsm_pkg::ROM_BYTES_RESET;
      bank_high_bits    <= '0;
      bank_low_bits     <= '0;
      bank_written      <= 1'b0;
      size_units        <= '0;
      size_written      <= 1'b0;
      boot_mode         <= 1'b1;
      mapped_base_units <= '0;
      mapped_size_units <= '0;
    end else begin
      // Configuration write
      if (psel && penable && pwrite && pready && (paddr[2] == cbsm_pkg::REG_ROM_BYTES)) begin
        rom_bytes <= pwdata[cbsm_pkg::ROM_W-1:0];
      end
      // Drop the result once taken, unless a new one is loaded in its place
      if (rsp_valid && rsp_ready && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item <= req;
            rem  <= '0;
            dvd  <= req.addr[cbsm_pkg::WIN_BITS-1:cbsm_pkg::UNIT_SHIFT];
            cnt  <= cbsm_pkg::CNT_W'(cbsm_pkg::QUOT_W - 1);
            state <= needs_divide ? ST_DIVIDE : ST_FINISH;
          end
        end
        ST_DIVIDE: begin
          // Advance one quotient bit
          rem <= rem_next;
          dvd <= dvd << 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (rsp_free) begin
            rsp       <= result;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
            if (item.command == cbsm_pkg::CMD_WRITE && known) begin
              bank_high_bits <= nbh;
              bank_low_bits  <= nbl;
              size_units     <= nsz;
              bank_written   <= nbw;
              size_written   <= nsw;
            end
            if (do_remap) begin
              mapped_base_units <= {nbh, nbl};
              mapped_size_units <= nsz;
              boot_mode         <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/cbsm_checker.sv */
module cbsm_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input cbsm_pkg::rsp_t rsp
);

  // A stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status <= cbsm_pkg::STATUS_UNKNOWN))
    else $error("undefined status code");

  // Only a translated read carries a ROM address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != cbsm_pkg::STATUS_READ_OK) |-> (rsp.rom_addr == '0))
    else $error("non-read result carries an address");

  // The sequencer is busy in the cycle after it takes a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready in the cycle after acceptance");

endmodule

bind cartridge_bank_size_mapper_core cbsm_checker u_cbsm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
